@@ rtl/bilinear_pixel_sampler_macros.svh @@
// assertion macros shared by the sampler modules
`ifndef BILINEAR_PIXEL_SAMPLER_MACROS_SVH
`define BILINEAR_PIXEL_SAMPLER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bps_pkg.sv @@
// shared constants, types and helpers of the bilinear pixel sampler
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    // image geometry and coordinate format
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int FRACTION_BITS = 8;

    // fixed field widths
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 18;
    localparam int CFG_W    = 9;
    localparam int OUT_W    = 24;
    localparam int S_DATA_W = 64;

    // input beat layout, lowest bit first
    localparam int COL_LSB = 0;
    localparam int ROW_LSB = COL_LSB + 8;
    localparam int VAL_LSB = ROW_LSB + 8;
    localparam int X_LSB   = VAL_LSB + PIX_W;
    localparam int Y_LSB   = X_LSB + COORD_W;

    // derived widths
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int IP_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int W_SIZE_W = $clog2(MAX_WIDTH + 1);
    localparam int H_SIZE_W = $clog2(MAX_HEIGHT + 1);
    localparam int BANK_AW  = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 4;

    // interpolation arithmetic
    localparam int WGT_W   = FRACTION_BITS + 1;
    localparam int H_W     = PIX_W + FRACTION_BITS;
    localparam int ACC_W   = PIX_W + 2 * FRACTION_BITS;
    localparam int OUT_FRAC = 16;
    localparam int OUT_SHR = (2 * FRACTION_BITS > OUT_FRAC) ? 2 * FRACTION_BITS - OUT_FRAC : 0;
    localparam int OUT_SHL = (2 * FRACTION_BITS < OUT_FRAC) ? OUT_FRAC - 2 * FRACTION_BITS : 0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item kinds
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    // neighbourhood and weights of one sample
    typedef struct packed {
        logic [PIX_W-1:0]         p00;
        logic [PIX_W-1:0]         p10;
        logic [PIX_W-1:0]         p01;
        logic [PIX_W-1:0]         p11;
        logic [FRACTION_BITS-1:0] fx;
        logic [FRACTION_BITS-1:0] fy;
    } quad_t;

    // samples still inside the front pipeline
    typedef struct packed {
        logic s1_busy;
        logic s2_busy;
    } front_stat_t;

    // clamped coordinate
    typedef struct packed {
        logic [IP_W-1:0]          ipart;
        logic [FRACTION_BITS-1:0] frac;
    } coord_t;

    // clamp to [0, size-1] and split into integer part and fraction
    function automatic coord_t split_coord(input logic signed [COORD_W-1:0] c,
                                           input logic [31:0] size);
        logic [31:0] mag;
        logic [31:0] lim;
        logic [31:0] v;
        coord_t      r;
        mag = 32'(c[COORD_W-2:0]);
        lim = size << FRACTION_BITS;
        if (c[COORD_W-1])
            v = '0;
        else if (mag >= lim)
            v = (size - 32'd1) << FRACTION_BITS;
        else
            v = mag;
        r.ipart = IP_W'(v >> FRACTION_BITS);
        r.frac  = FRACTION_BITS'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bps_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/bps_front.sv @@
// front: clamps coordinates, writes pixels and reads the 2x2 neighbourhood
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_pixel_sampler_macros.svh"

module bps_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           mode,
    input  wire logic [7:0]                     pixel_col,
    input  wire logic [7:0]                     pixel_row,
    input  wire logic [bps_pkg::PIX_W-1:0]      pixel_value,
    input  wire logic signed [bps_pkg::COORD_W-1:0] sample_x,
    input  wire logic signed [bps_pkg::COORD_W-1:0] sample_y,
    input  wire logic [bps_pkg::W_SIZE_W-1:0]   img_w,
    input  wire logic [bps_pkg::H_SIZE_W-1:0]   img_h,
    output bps_pkg::front_stat_t                stat,
    output logic                                push,
    output bps_pkg::quad_t                      push_item
);

    import bps_pkg::*;

    // stage 1: clamped coordinates or write target
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_write_reg, s1_write_next;
    logic                     s1_wok_reg, s1_wok_next;
    logic [COL_W-1:0]         s1_ix_reg, s1_ix_next;
    logic [ROW_W-1:0]         s1_iy_reg, s1_iy_next;
    logic [FRACTION_BITS-1:0] s1_fx_reg, s1_fx_next;
    logic [FRACTION_BITS-1:0] s1_fy_reg, s1_fy_next;
    logic [PIX_W-1:0]         s1_wdata_reg, s1_wdata_next;

    // stage 2: read in flight, bank parities for the pixel select
    logic                     s2_valid_reg, s2_valid_next;
    logic [FRACTION_BITS-1:0] s2_fx_reg, s2_fy_reg;
    logic                     s2_x0p_reg, s2_x1p_reg, s2_y0p_reg, s2_y1p_reg;

    coord_t           cx, cy;
    logic [COL_W-1:0] ix1;
    logic [ROW_W-1:0] iy1;
    logic [PIX_W-1:0] bank_rd [NUM_BANKS];

    // stage 0: classify the beat and clamp the coordinates
    always_comb
    begin
        cx = split_coord(sample_x, 32'(img_w));
        cy = split_coord(sample_y, 32'(img_h));
        s1_valid_next = in_valid;
        s1_write_next = (mode == MODE_WRITE);
        s1_wdata_next = pixel_value;
        s1_wok_next   = (32'(pixel_col) < MAX_WIDTH) && (32'(pixel_row) < MAX_HEIGHT);
        if (mode == MODE_WRITE)
        begin
            s1_ix_next = COL_W'(pixel_col);
            s1_iy_next = ROW_W'(pixel_row);
            s1_fx_next = '0;
            s1_fy_next = '0;
        end
        else
        begin
            s1_ix_next = COL_W'(cx.ipart);
            s1_iy_next = ROW_W'(cy.ipart);
            s1_fx_next = cx.frac;
            s1_fy_next = cy.frac;
        end
    end

    // stage 1: right and lower neighbours, held at the edge
    always_comb
    begin
        ix1 = ((32'(s1_ix_reg) + 32'd1) < 32'(img_w)) ? COL_W'(32'(s1_ix_reg) + 32'd1)
                                                      : s1_ix_reg;
        iy1 = ((32'(s1_iy_reg) + 32'd1) < 32'(img_h)) ? ROW_W'(32'(s1_iy_reg) + 32'd1)
                                                      : s1_iy_reg;
        s2_valid_next = s1_valid_reg && !s1_write_reg;
    end

    // four banks by row and column parity
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic CP = 1'(b % 2);
        localparam logic RP = 1'(b / 2);
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [BANK_AW-1:0] raddr;
        logic [BANK_AW-1:0] waddr;
        logic               we;
        logic               re;

        always_comb
        begin
            col   = (s1_ix_reg[0] == CP) ? s1_ix_reg : ix1;
            row   = (s1_iy_reg[0] == RP) ? s1_iy_reg : iy1;
            raddr = {row[ROW_W-1:1], col[COL_W-1:1]};
            waddr = {s1_iy_reg[ROW_W-1:1], s1_ix_reg[COL_W-1:1]};
            we    = s1_valid_reg && s1_write_reg && s1_wok_reg
                    && (s1_ix_reg[0] == CP) && (s1_iy_reg[0] == RP);
            re    = s1_valid_reg && !s1_write_reg;
        end

        bps_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (s1_wdata_reg),
            .re    (re),
            .raddr (raddr),
            .rdata (bank_rd[b])
        );
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_write_reg <= s1_write_next;
        s1_wok_reg   <= s1_wok_next;
        s1_ix_reg    <= s1_ix_next;
        s1_iy_reg    <= s1_iy_next;
        s1_fx_reg    <= s1_fx_next;
        s1_fy_reg    <= s1_fy_next;
        s1_wdata_reg <= s1_wdata_next;
        s2_fx_reg    <= s1_fx_reg;
        s2_fy_reg    <= s1_fy_reg;
        s2_x0p_reg   <= s1_ix_reg[0];
        s2_x1p_reg   <= ix1[0];
        s2_y0p_reg   <= s1_iy_reg[0];
        s2_y1p_reg   <= iy1[0];
    end

    // pick the four neighbours out of the banks
    always_comb
    begin
        push_item.p00 = bank_rd[{s2_y0p_reg, s2_x0p_reg}];
        push_item.p10 = bank_rd[{s2_y0p_reg, s2_x1p_reg}];
        push_item.p01 = bank_rd[{s2_y1p_reg, s2_x0p_reg}];
        push_item.p11 = bank_rd[{s2_y1p_reg, s2_x1p_reg}];
        push_item.fx  = s2_fx_reg;
        push_item.fy  = s2_fy_reg;
    end

    assign push          = s2_valid_reg;
    assign stat.s1_busy  = s1_valid_reg && !s1_write_reg;
    assign stat.s2_busy  = s2_valid_reg;

    `BPS_ASSERT_NEXT(a_read_reaches_queue, s1_valid_reg && !s1_write_reg, push, "sample read lost before queue")

endmodule

`default_nettype wire

@@ rtl/bps_queue.sv @@
// short queue of neighbourhoods between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_pixel_sampler_macros.svh"

module bps_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire bps_pkg::quad_t         push_item,
    input  wire logic                   pop,
    output logic                        head_valid,
    output bps_pkg::quad_t              head_item,
    output logic [bps_pkg::QCNT_W-1:0]  count
);

    import bps_pkg::*;

    quad_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(32'(wr_ptr_reg) + 32'd1 == QUEUE_DEPTH ? 32'd0
                                    : 32'(wr_ptr_reg) + 32'd1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(32'(rd_ptr_reg) + 32'd1 == QUEUE_DEPTH ? 32'd0
                                    : 32'(rd_ptr_reg) + 32'd1) : rd_ptr_reg;
        count_next  = QCNT_W'(32'(count_reg) + 32'(push) - 32'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    `BPS_ASSERT_SAME(a_q_no_overflow, push, (count_reg != QCNT_W'(QUEUE_DEPTH)) || pop, "queue overflow")
    `BPS_ASSERT_SAME(a_q_no_underflow, pop, count_reg != '0, "queue underflow")
    `BPS_ASSERT_NEXT(a_q_grow, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count slip")

endmodule

`default_nettype wire

@@ rtl/bps_back.sv @@
// back: bilinear weighting of the neighbourhood and the output register
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_pixel_sampler_macros.svh"

module bps_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      head_valid,
    input  wire bps_pkg::quad_t            head_item,
    output logic                           pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [bps_pkg::OUT_W-1:0]      m_tdata
);

    import bps_pkg::*;

    localparam logic [WGT_W-1:0] ONE = WGT_W'(1 << FRACTION_BITS);

    logic                     b1_valid_reg, b1_valid_next;
    logic [H_W-1:0]           b1_top_reg, b1_top_next;
    logic [H_W-1:0]           b1_bot_reg, b1_bot_next;
    logic [FRACTION_BITS-1:0] b1_fy_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]         out_data_reg, out_data_next;

    logic             adv;
    logic [WGT_W-1:0] wx0, wx1, wy0, wy1;
    logic [ACC_W-1:0] acc;

    // the whole back moves when the output slot is free or taken
    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && head_valid;

    // horizontal pass: top and bottom rows weighted by the x fraction
    always_comb
    begin
        wx1 = WGT_W'(head_item.fx);
        wx0 = ONE - wx1;
        b1_valid_next = head_valid;
        b1_top_next = H_W'((H_W + 1)'(head_item.p00) * (H_W + 1)'(wx0)
                         + (H_W + 1)'(head_item.p10) * (H_W + 1)'(wx1));
        b1_bot_next = H_W'((H_W + 1)'(head_item.p01) * (H_W + 1)'(wx0)
                         + (H_W + 1)'(head_item.p11) * (H_W + 1)'(wx1));
    end

    // vertical pass and scaling to q8.16
    always_comb
    begin
        wy1 = WGT_W'(b1_fy_reg);
        wy0 = ONE - wy1;
        acc = ACC_W'((ACC_W + 1)'(b1_top_reg) * (ACC_W + 1)'(wy0)
                   + (ACC_W + 1)'(b1_bot_reg) * (ACC_W + 1)'(wy1));
        out_valid_next = b1_valid_reg;
        out_data_next  = OUT_W'((32'(acc) << OUT_SHL) >> OUT_SHR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_top_reg   <= b1_top_next;
            b1_bot_reg   <= b1_bot_next;
            b1_fy_reg    <= head_item.fy;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `BPS_ASSERT_NEXT(a_b1_hold, b1_valid_reg && !adv, b1_valid_reg, "weighted row dropped while stalled")

endmodule

`default_nettype wire

@@ rtl/bilinear_pixel_sampler.sv @@
// top level of the bilinear pixel sampler
//
//  channel   dir  handshake          content
//  s_*       in   s_tvalid/s_tready  pixel write or sample query, kind in s_tuser
//  m_*       out  m_tvalid/m_tready  interpolated sample, unsigned q8.16
//  cfg_*     in   cfg_we             image width (index 0), image height (index 1)
//
// one beat per cycle while s_tready is high; writes and queries mix freely.
// a query's result goes through clamp, bank read, queue, horizontal pass and
// vertical pass, in that order, before it shows on m_*; writes give no result.
// the four parity banks hand out the whole 2x2 neighbourhood in one read.
// s_tready falls only when the 4-entry queue plus queries in flight would fill it.
// reset clears control only; the image store holds nothing until written.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_pixel_sampler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // col[7:0], row[15:8], value[23:16], x[41:24], y[59:42], zero fill
    input  wire logic [bps_pkg::S_DATA_W-1:0]   s_tdata,
    // mode[0]
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // sample_value[23:0]
    output logic [bps_pkg::OUT_W-1:0]           m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [bps_pkg::CFG_W-1:0]      cfg_data
);

    import bps_pkg::*;

    logic [CFG_W-1:0]    width_reg, width_next;
    logic [CFG_W-1:0]    height_reg, height_next;
    logic [W_SIZE_W-1:0] img_w;
    logic [H_SIZE_W-1:0] img_h;

    front_stat_t       stat;
    logic              push;
    quad_t             push_item;
    logic              pop;
    logic              head_valid;
    quad_t             head_item;
    logic [QCNT_W-1:0] q_count;
    logic              in_valid;

    // register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_RESET;
            height_reg <= CFG_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // zero acts as one, oversize saturates
    always_comb
    begin
        if (width_reg == '0)
            img_w = W_SIZE_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            img_w = W_SIZE_W'(MAX_WIDTH);
        else
            img_w = W_SIZE_W'(width_reg);
        if (height_reg == '0)
            img_h = H_SIZE_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            img_h = H_SIZE_W'(MAX_HEIGHT);
        else
            img_h = H_SIZE_W'(height_reg);
    end

    // room for every query already past the input
    assign s_tready = (32'(q_count) + 32'(stat.s1_busy) + 32'(stat.s2_busy))
                      < 32'(QUEUE_DEPTH);
    assign in_valid = s_tvalid && s_tready;

    bps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .mode        (s_tuser),
        .pixel_col   (s_tdata[ROW_LSB-1:COL_LSB]),
        .pixel_row   (s_tdata[VAL_LSB-1:ROW_LSB]),
        .pixel_value (s_tdata[X_LSB-1:VAL_LSB]),
        .sample_x    (s_tdata[Y_LSB-1:X_LSB]),
        .sample_y    (s_tdata[Y_LSB+COORD_W-1:Y_LSB]),
        .img_w       (img_w),
        .img_h       (img_h),
        .stat        (stat),
        .push        (push),
        .push_item   (push_item)
    );

    bps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    bps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// testbench for the bilinear pixel sampler: directed and random pixel writes and sample queries
`timescale 1ns / 1ps

module testbench;

    import bps_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_PAUSE  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;

    // one input beat before packing
    typedef struct packed {
        logic               mode;
        logic [7:0]         col;
        logic [7:0]         row;
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pixel_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_we = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // mirror of the block state
    logic [PIX_W-1:0]       pixel_mirror [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    bit                     pixel_known [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    logic [CFG_W-1:0]       width_reg = CFG_RESET;
    logic [CFG_W-1:0]       height_reg = CFG_RESET;

    logic [OUT_W-1:0]       pending_samples [$];
    int                     fault_count = 0;
    int unsigned            cycle_count = 0;
    bit                     steady = 1'b0;
    bit                     hold_request = 1'b0;

    bilinear_pixel_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // register value to usable size
    function automatic int span(input logic [CFG_W-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    // clamp one coordinate into the image, split into integer part and fraction
    function automatic void clamp_axis(input logic [COORD_W-1:0] c, input int size,
                                       output int ipart, output int frac);
        int v;
        v = int'($signed(c));
        if (v < 0)
            v = 0;
        else if (v >= (size << FRACTION_BITS))
            v = (size - 1) << FRACTION_BITS;
        ipart = v >> FRACTION_BITS;
        frac  = v & ((1 << FRACTION_BITS) - 1);
    endfunction

    // weighted 2x2 sum in q8.16, edge neighbours repeat the last pixel
    function automatic logic [OUT_W-1:0] bilinear_value(input pixel_beat_t b);
        int     w, h, ix, iy, fx, fy, ix1, iy1, one;
        longint acc;
        w = span(width_reg, MAX_WIDTH);
        h = span(height_reg, MAX_HEIGHT);
        clamp_axis(b.x, w, ix, fx);
        clamp_axis(b.y, h, iy, fy);
        ix1 = (ix + 1 < w) ? ix + 1 : w - 1;
        iy1 = (iy + 1 < h) ? iy + 1 : h - 1;
        one = 1 << FRACTION_BITS;
        acc = longint'(one - fx) * (one - fy) * pixel_mirror[iy][ix]
            + longint'(fx) * (one - fy) * pixel_mirror[iy][ix1]
            + longint'(one - fx) * fy * pixel_mirror[iy1][ix]
            + longint'(fx) * fy * pixel_mirror[iy1][ix1];
        if (2 * FRACTION_BITS > OUT_FRAC)
            acc = acc >> (2 * FRACTION_BITS - OUT_FRAC);
        else
            acc = acc << (OUT_FRAC - 2 * FRACTION_BITS);
        return OUT_W'(acc);
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return PIX_W'($urandom);
    endfunction

    // in range, anywhere, near the far edge, or just below zero
    function automatic logic [COORD_W-1:0] pick_coord(input int size);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return COORD_W'($urandom_range(0, (size << FRACTION_BITS) - 1));
        if (r < 75)
            return COORD_W'($urandom);
        if (r < 92)
            return COORD_W'(((size - 1 + $urandom_range(0, 1)) << FRACTION_BITS)
                            + $urandom_range(0, (1 << FRACTION_BITS) - 1));
        return COORD_W'(-$signed($urandom_range(1, 300)));
    endfunction

    function automatic pixel_beat_t write_beat(input logic [7:0] col, input logic [7:0] row,
                                               input logic [PIX_W-1:0] value);
        pixel_beat_t b;
        b.mode  = MODE_WRITE;
        b.col   = col;
        b.row   = row;
        b.value = value;
        b.x     = COORD_W'($urandom);
        b.y     = COORD_W'($urandom);
        return b;
    endfunction

    function automatic pixel_beat_t sample_beat(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
        pixel_beat_t b;
        b.mode  = MODE_SAMPLE;
        b.col   = 8'($urandom);
        b.row   = 8'($urandom);
        b.value = PIX_W'($urandom);
        b.x     = x;
        b.y     = y;
        return b;
    endfunction

    // offer one beat, wait for it to be taken, then update the mirror
    task automatic send_beat(input pixel_beat_t b);
        int                  gap;
        logic [S_DATA_W-1:0] data;
        gap  = pick_gap();
        data = '0;
        data[COL_LSB +: 8]       = b.col;
        data[ROW_LSB +: 8]       = b.row;
        data[VAL_LSB +: PIX_W]   = b.value;
        data[X_LSB +: COORD_W]   = b.x;
        data[Y_LSB +: COORD_W]   = b.y;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.mode;
        s_tdata  <= data;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        if (b.mode == MODE_WRITE)
        begin
            pixel_mirror[b.row][b.col] = b.value;
            pixel_known[b.row][b.col]  = 1'b1;
        end
        else
            pending_samples = {pending_samples, bilinear_value(b)};
    endtask

    // let the block run dry, then reprogram the image size
    task automatic program_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        width_reg  = w;
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        height_reg = h;
        cfg_we    <= 1'b0;
    endtask

    // write every pixel of the active image that has never been written
    task automatic fill_image();
        int w, h;
        w = span(width_reg, MAX_WIDTH);
        h = span(height_reg, MAX_HEIGHT);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                if (!pixel_known[r][c])
                    send_beat(write_beat(8'(c), 8'(r), pick_value()));
    endtask

    // random mix of writes and queries over the filled image, some aimed outside it
    task automatic run_mix(input int count);
        int          w, h;
        pixel_beat_t b;
        w = span(width_reg, MAX_WIDTH);
        h = span(height_reg, MAX_HEIGHT);
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    b = write_beat(8'($urandom), 8'($urandom), pick_value());
                else
                    b = write_beat(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
                                   pick_value());
            end
            else
                b = sample_beat(pick_coord(w), pick_coord(h));
            send_beat(b);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // full 256x256 image after reset, only a few pixels written
    task automatic test_directed();
        send_beat(write_beat(8'd0, 8'd0, 8'd0));
        send_beat(write_beat(8'd1, 8'd0, 8'd255));
        send_beat(write_beat(8'd0, 8'd1, 8'd128));
        send_beat(write_beat(8'd1, 8'd1, 8'd77));
        send_beat(write_beat(8'd255, 8'd255, 8'd255));
        // origin, half steps, fraction of all ones
        send_beat(sample_beat(18'h00000, 18'h00000));
        send_beat(sample_beat(18'h00080, 18'h00080));
        send_beat(sample_beat(18'h000ff, 18'h00001));
        // negative coordinates clamp to zero
        send_beat(sample_beat(18'h30000, 18'h3ffff));
        send_beat(sample_beat(18'h00040, 18'h30000));
        // largest coordinates clamp to the last pixel, neighbours held on the edge
        send_beat(sample_beat(18'h1ffff, 18'h1ffff));
        send_beat(sample_beat(18'h0ffff, 18'h0ffff));
        send_beat(sample_beat(18'h10000, 18'h10000));
        // overwrite followed at once by reads of the same pixels
        steady = 1'b1;
        send_beat(write_beat(8'd0, 8'd0, 8'd200));
        send_beat(sample_beat(18'h00010, 18'h00010));
        send_beat(write_beat(8'd1, 8'd1, 8'd255));
        send_beat(sample_beat(18'h000c0, 18'h000c0));
        steady = 1'b0;
    endtask

    // zero and oversize register values, single row, single column, single pixel
    task automatic test_size_extremes();
        program_size(9'd511, 9'd1);
        fill_image();
        run_mix(50);
        program_size(9'd0, 9'd257);
        fill_image();
        run_mix(50);
        program_size(9'd1, 9'd1);
        run_mix(25);
    endtask

    // small random image sizes, one phase without idling
    task automatic test_random_sizes();
        logic [CFG_W-1:0] w, h;
        for (int phase = 0; phase < 8; phase++)
        begin
            w = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 12));
            h = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 12));
            program_size(w, h);
            fill_image();
            steady = (phase == 3);
            run_mix(105);
            steady = 1'b0;
        end
    endtask

    // receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        int w, h;
        w = span(width_reg, MAX_WIDTH);
        h = span(height_reg, MAX_HEIGHT);
        hold_request = 1'b1;
        steady = 1'b1;
        repeat (40)
            send_beat(sample_beat(pick_coord(w), pick_coord(h)));
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // receiver ready with random stalls and one long hold
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 15)
                    stall_left = pick_gap();
            end
        end
    end

    // compare each result beat taken at the coming edge
    always @(negedge clk)
    begin
        logic [OUT_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
                log_fault($sformatf("result beat with no query pending: got %0d", m_tdata));
            else
            begin
                want = pending_samples.pop_front();
                if (m_tdata !== want)
                    log_fault($sformatf("sample_value mismatch: expected %0d, got %0d",
                                        want, m_tdata));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_size_extremes();
        test_random_sizes();
        test_backpressure();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_samples.size() != 0)
            log_fault($sformatf("%0d samples never returned", pending_samples.size()));
        if (fault_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_ram.sv
rtl/bps_front.sv
rtl/bps_queue.sv
rtl/bps_back.sv
rtl/bilinear_pixel_sampler.sv
sim/testbench.sv
